FILE: sv/chnht_pkg.sv
// Shared types and constants for the cost-sorted next-hop table.
`timescale 1ns / 1ps
`default_nettype none
package chnht_pkg;

   // Table geometry
   localparam int MAX_HOPS  = 16;
   localparam int HOP_CNT_W = $clog2(MAX_HOPS + 1);

   // Field widths
   localparam int OP_W   = 2;
   localparam int FACE_W = 16;
   localparam int COST_W = 64;
   localparam int RANK_W = 4;
   localparam int CNT_W  = 5;

   // Stream payload widths (padded to whole bytes)
   localparam int REQ_FIELDS_W = FACE_W + COST_W + RANK_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 1 + CNT_W + 1 + 1 + FACE_W + COST_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Request queue depth
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Operation codes
   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   // Decoded operation class
   typedef struct packed {
      logic is_add;
      logic is_remove;
      logic is_lookup;
      logic is_read;
   } op_class_type;

   // Classified request handed from the front queue to the engine
   typedef struct packed {
      op_class_type             kind;
      logic [FACE_W-1:0]        face;
      logic [COST_W-1:0]        cost;
      logic [RANK_W-1:0]        rank;
   } req_item_type;

endpackage
`default_nettype wire

FILE: sv/cost_sorted_next_hop_table.sv
// Top level of the cost-sorted next-hop table.
//
// Keeps up to MAX_HOPS (face, cost) entries in ascending cost order.
// Request channel (req_): tuser carries the operation (add/update, remove,
// lookup, read rank); tdata carries face, cost and rank. Each request gives
// exactly one response on the rsp_ channel.
// A request is first held in a two-entry front queue, then run by the engine:
// in the compare state it compares the face and cost against all table slots in parallel,
// then in the apply state it shifts the table and loads the response register.
// The engine starts a new request only as the current one leaves its apply
// state, so compare and apply alternate; the front queue can take requests meanwhile.
// The table lives in flip-flops; an added or updated entry goes after equal
// costs, an add to a full table is dropped and flagged in table_full.
// Reset empties the table at once (count zero), no clearing pass.
// When the receiver stalls, the response waits in its register and the engine
// holds the next request in its apply cycle; the front queue keeps taking
// requests until its two entries are full.
`timescale 1ns / 1ps
`default_nettype none
module cost_sorted_next_hop_table
   import chnht_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   // face_id [15:0], hop_cost_in [79:16], rank_index [83:80], zero pad
   input  wire  [REQ_DATA_W-1:0] req_tdata,
   // operation [1:0]
   input  wire  [OP_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   // face_present [0], entry_count [5:1], table_full [6], rank_valid [7],
   // rank_face [23:8], rank_cost [87:24]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic          head_valid;
   req_item_type  head_item;
   logic          head_pop;

   chnht_req_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop)
   );

   chnht_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Engine never takes a request from an empty queue
   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("request popped from empty queue");

   // Reported count never exceeds table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (int'(rsp_tdata[5:1]) <= MAX_HOPS))
      else $error("entry count above table size");

   // A dropped add reports neither a present face nor a rank
   a_full_exclusive: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[6]) |-> (!rsp_tdata[0] && !rsp_tdata[7]))
      else $error("table_full with other flags set");

   // An invalid rank read returns zero payload
   a_rank_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[7]) |-> (rsp_tdata[87:8] == '0))
      else $error("rank payload nonzero without rank_valid");

endmodule
`default_nettype wire

FILE: sv/chnht_req_queue.sv
// Front end: accepts requests, decodes the operation and queues them.
`timescale 1ns / 1ps
`default_nettype none
module chnht_req_queue
   import chnht_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   // face_id [15:0], hop_cost_in [79:16], rank_index [83:80], zero pad
   input  wire  [REQ_DATA_W-1:0] req_tdata,
   // operation [1:0]
   input  wire  [OP_W-1:0]       req_tuser,
   output logic                  head_valid,
   output req_item_type          head_item,
   input  wire                   head_pop
);

   req_item_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]        fill_ff, fill_in;
   req_item_type             new_item;
   logic                     push;
   logic                     pop;

   // Classify the incoming request
   always_comb begin
      new_item.kind = '0;
      unique case (op_type'(req_tuser))
         OP_ADD:    new_item.kind.is_add    = 1'b1;
         OP_REMOVE: new_item.kind.is_remove = 1'b1;
         OP_LOOKUP: new_item.kind.is_lookup = 1'b1;
         OP_READ:   new_item.kind.is_read   = 1'b1;
         default:   new_item.kind           = '0;
      endcase
      new_item.face = req_tdata[FACE_W-1:0];
      new_item.cost = req_tdata[FACE_W+COST_W-1:FACE_W];
      new_item.rank = req_tdata[REQ_FIELDS_W-1:FACE_W+COST_W];
   end

   assign req_tready = (fill_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign head_valid = (fill_ff != '0);
   assign pop        = head_pop && head_valid;
   assign head_item  = slot_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Payload slots, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

FILE: sv/chnht_engine.sv
// Back end: compares against the table, applies the update and registers the response.
`timescale 1ns / 1ps
`default_nettype none
module chnht_engine
   import chnht_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   head_valid,
   input  req_item_type          head_item,
   output logic                  head_pop,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   // face_present [0], entry_count [5:1], table_full [6], rank_valid [7],
   // rank_face [23:8], rank_cost [87:24]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_APPLY
   } state_type;

   state_type                 state_ff;
   req_item_type              cur_ff;
   logic [FACE_W-1:0]         face_ff [MAX_HOPS];
   logic [COST_W-1:0]         cost_ff [MAX_HOPS];
   logic [HOP_CNT_W-1:0]      count_ff;
   logic [MAX_HOPS-1:0]       match_ff, match_in;
   logic [MAX_HOPS-1:0]       le_ff, le_in;
   logic                      out_valid_ff;
   logic [RSP_DATA_W-1:0]     out_data_ff, out_data_in;

   logic                      out_free;
   logic                      present;
   logic                      table_at_max;
   logic                      do_insert;
   logic                      do_write;
   logic [HOP_CNT_W-1:0]      count_next;
   logic [MAX_HOPS-1:0]       before_p;
   logic [MAX_HOPS-1:0]       c_le;
   logic [FACE_W-1:0]         c_face [MAX_HOPS];
   logic [COST_W-1:0]         c_cost [MAX_HOPS];
   logic [FACE_W-1:0]         n_face [MAX_HOPS];
   logic [COST_W-1:0]         n_cost [MAX_HOPS];
   logic                      rank_ok;
   logic [FACE_W-1:0]         rank_face;
   logic [COST_W-1:0]         rank_cost;
   logic                      res_full;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // Compare stage: face match and cost-not-greater over the valid slots
   always_comb begin
      for (int i = 0; i < MAX_HOPS; i++) begin
         match_in[i] = (HOP_CNT_W'(i) < count_ff) && (face_ff[i] == cur_ff.face);
         le_in[i]    = (HOP_CNT_W'(i) < count_ff) && (cost_ff[i] <= cur_ff.cost);
      end
   end

   // Apply stage: take out the matched entry, then insert after equal costs
   always_comb begin
      logic acc;
      acc          = 1'b0;
      present      = |match_ff;
      table_at_max = (count_ff == HOP_CNT_W'(MAX_HOPS));
      // slots below the matched one keep their place
      for (int i = MAX_HOPS - 1; i >= 0; i--) begin
         before_p[i] = !present || acc;
         acc         = acc | match_ff[i];
      end
      // compacted view after removal of the matched entry
      for (int i = 0; i < MAX_HOPS; i++) begin
         if (before_p[i] || (i == MAX_HOPS - 1)) begin
            c_face[i] = face_ff[i];
            c_cost[i] = cost_ff[i];
            c_le[i]   = before_p[i] && le_ff[i];
         end else begin
            c_face[i] = face_ff[i+1];
            c_cost[i] = cost_ff[i+1];
            c_le[i]   = le_ff[i+1];
         end
      end
      // insertion into the compacted view
      for (int i = 0; i < MAX_HOPS; i++) begin
         if (!cur_ff.kind.is_add || c_le[i]) begin
            n_face[i] = c_face[i];
            n_cost[i] = c_cost[i];
         end else if ((i == 0) || c_le[i-1]) begin
            n_face[i] = cur_ff.face;
            n_cost[i] = cur_ff.cost;
         end else begin
            n_face[i] = c_face[i-1];
            n_cost[i] = c_cost[i-1];
         end
      end
      do_insert = cur_ff.kind.is_add && (present || !table_at_max);
      do_write  = do_insert || (cur_ff.kind.is_remove && present);
      res_full  = cur_ff.kind.is_add && !present && table_at_max;
      count_next = count_ff;
      if (cur_ff.kind.is_add && !present && !table_at_max) begin
         count_next = count_ff + 1'b1;
      end else if (cur_ff.kind.is_remove && present) begin
         count_next = count_ff - 1'b1;
      end
   end

   // Rank read
   always_comb begin
      rank_ok   = cur_ff.kind.is_read && (int'(cur_ff.rank) < int'(count_ff));
      rank_face = '0;
      rank_cost = '0;
      for (int i = 0; i < MAX_HOPS; i++) begin
         if (rank_ok && (int'(cur_ff.rank) == i)) begin
            rank_face = face_ff[i];
            rank_cost = cost_ff[i];
         end
      end
   end

   // Response word
   always_comb begin
      out_data_in = '0;
      out_data_in[RSP_FIELDS_W-1:0] = {rank_cost, rank_face, rank_ok, res_full,
                                       CNT_W'(count_next),
                                       present && !cur_ff.kind.is_read};
   end

   // Next request is taken when idle, or as the current one retires
   assign head_pop = head_valid &&
                     ((state_ff == ST_IDLE) || ((state_ff == ST_APPLY) && out_free));

   // Sequencer with registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_tready && !((state_ff == ST_APPLY) && out_free)) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (head_valid) begin
                  state_ff <= ST_CMP;
               end
            end
            ST_CMP: begin
               state_ff <= ST_APPLY;
            end
            ST_APPLY: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  count_ff     <= count_next;
                  state_ff     <= head_valid ? ST_CMP : ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Datapath registers, no reset
   always_ff @(posedge clock) begin
      if (head_pop) begin
         cur_ff <= head_item;
      end
      if (state_ff == ST_CMP) begin
         match_ff <= match_in;
         le_ff    <= le_in;
      end
      if ((state_ff == ST_APPLY) && out_free) begin
         out_data_ff <= out_data_in;
         if (do_write) begin
            for (int i = 0; i < MAX_HOPS; i++) begin
               face_ff[i] <= n_face[i];
               cost_ff[i] <= n_cost[i];
            end
         end
      end
   end

endmodule
`default_nettype wire
